// File: rtl/core/lqvt_pkg.sv
package lqvt_pkg;

   localparam int FIFO_DEPTH_DEF  = 64;
   localparam int LEASE_SLOTS_DEF = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      REQ_PUBLISH = 2'd0,
      REQ_RECEIVE = 2'd1,
      REQ_ACK     = 2'd2,
      REQ_TICK    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request word
      logic do_publish;  // write fifo tail
      logic rd_head;     // issue fifo head read
      logic do_receive;  // commit receive into lease slot
      logic do_ack;      // free matched slot
      logic tick_clear;  // start tick scan
      logic tick_step;   // process scan slot
      logic tick_push;   // write expired lease to fifo tail
      logic set_status;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      req_kind_type kind;
      logic fifo_room;
      logic fifo_nonempty;
      logic slot_free;
      logic ack_match;
      logic scan_last;
      logic scan_expire;
   } stat_type;

endpackage

// File: rtl/core/lqvt_if.sv
interface lqvt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] payload;
   logic [11:0] handle;
   modport source (output valid, req_type, payload, handle, input ready);
   modport sink   (input valid, req_type, payload, handle, output ready);
endinterface

interface lqvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_payload;
   logic [7:0]  receive_count;
   logic [11:0] out_handle;
   logic [4:0]  requeued_count;
   modport source (output valid, status, out_payload, receive_count, out_handle,
                   requeued_count, input ready);
   modport sink   (input valid, status, out_payload, receive_count, out_handle,
                   requeued_count, output ready);
endinterface

// File: rtl/core/lqvt_datapath.sv
module lqvt_datapath #(
   parameter int FIFO_DEPTH  = lqvt_pkg::FIFO_DEPTH_DEF,
   parameter int LEASE_SLOTS = lqvt_pkg::LEASE_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        timeout,
   input  logic [1:0]         in_type,
   input  logic [31:0]        in_payload,
   input  logic [11:0]        in_handle,
   input  lqvt_pkg::cmd_type  cmd,
   output lqvt_pkg::stat_type stat,
   output logic [1:0]         o_status,
   output logic [31:0]        o_payload,
   output logic [7:0]         o_count,
   output logic [11:0]        o_handle,
   output logic [4:0]         o_requeued
);
   localparam int FA = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FC = $clog2(FIFO_DEPTH + 1);
   localparam int SA = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam int SC = $clog2(LEASE_SLOTS + 1);

   logic [31:0] fifo_pay_mem [FIFO_DEPTH];
   logic [7:0]  fifo_cnt_mem [FIFO_DEPTH];
   logic [31:0] head_pay_ff;
   logic [7:0]  head_cnt_ff;

   logic [FA-1:0] head_ff, head_in;
   logic [FC-1:0] fill_ff, fill_in;
   logic [SC-1:0] held_ff, held_in;
   logic [LEASE_SLOTS-1:0] valid_ff, valid_in;
   logic [7:0]  gen_ff [LEASE_SLOTS];
   logic [31:0] spay_ff [LEASE_SLOTS];
   logic [7:0]  scnt_ff [LEASE_SLOTS];
   logic [15:0] srem_ff [LEASE_SLOTS];

   logic [1:0]  type_ff;
   logic [31:0] rpay_ff;
   logic [11:0] rhnd_ff;
   logic [SA-1:0] scan_ff;
   logic [4:0]  req_ff;

   logic [FA-1:0] tail;
   logic [SA-1:0] free_idx;
   logic          free_any;
   logic [SA-1:0] ack_idx;
   logic          ack_ok;
   logic [31:0]   push_pay;
   logic [7:0]    push_cnt;
   logic [FC:0]   tail_sum;
   logic [7:0]    cnt_inc;

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = LEASE_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SA'(i);
            free_any = 1'b1;
         end
      end
   end

   assign tail_sum = (FC+1)'(head_ff) + (FC+1)'(fill_ff);
   assign tail = (tail_sum >= (FC+1)'(FIFO_DEPTH)) ?
                 FA'(tail_sum - (FC+1)'(FIFO_DEPTH)) : FA'(tail_sum);

   assign ack_idx = SA'(rhnd_ff[3:0]);
   assign ack_ok = ({28'd0, rhnd_ff[3:0]} < 32'(LEASE_SLOTS)) && valid_ff[ack_idx]
                   && (gen_ff[ack_idx] == rhnd_ff[11:4]);

   assign push_pay = cmd.tick_push ? spay_ff[scan_ff] : rpay_ff;
   assign push_cnt = cmd.tick_push ? scnt_ff[scan_ff] : 8'd0;
   assign cnt_inc  = (head_cnt_ff == 8'hFF) ? head_cnt_ff : head_cnt_ff + 8'd1;

   assign stat.kind          = lqvt_pkg::req_kind_type'(type_ff);
   assign stat.fifo_room     = ((FC+1)'(fill_ff) + (FC+1)'(held_ff)) < (FC+1)'(FIFO_DEPTH);
   assign stat.fifo_nonempty = fill_ff != '0;
   assign stat.slot_free     = free_any;
   assign stat.ack_match     = ack_ok;
   assign stat.scan_last     = 32'(scan_ff) == 32'(LEASE_SLOTS - 1);
   assign stat.scan_expire   = valid_ff[scan_ff] && (srem_ff[scan_ff] <= 16'd1);

   always_ff @(posedge clock) begin
      if (cmd.do_publish || cmd.tick_push) begin
         fifo_pay_mem[tail] <= push_pay;
         fifo_cnt_mem[tail] <= push_cnt;
      end
      if (cmd.rd_head) begin
         head_pay_ff <= fifo_pay_mem[head_ff];
         head_cnt_ff <= fifo_cnt_mem[head_ff];
      end
   end

   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      held_in  = held_ff;
      valid_in = valid_ff;
      if (cmd.do_publish || cmd.tick_push)
         fill_in = fill_ff + FC'(1);
      if (cmd.tick_push) begin
         valid_in[scan_ff] = 1'b0;
         held_in = held_ff - SC'(1);
      end
      if (cmd.do_receive) begin
         head_in = (32'(head_ff) == FIFO_DEPTH - 1) ? '0 : head_ff + FA'(1);
         fill_in = fill_ff - FC'(1);
         valid_in[free_idx] = 1'b1;
         held_in = held_ff + SC'(1);
      end
      if (cmd.do_ack) begin
         valid_in[ack_idx] = 1'b0;
         held_in = held_ff - SC'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fill_ff  <= '0;
         held_ff  <= '0;
         valid_ff <= '0;
         for (int i = 0; i < LEASE_SLOTS; i++) gen_ff[i] <= 8'd0;
      end else begin
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
         if (cmd.do_receive) gen_ff[free_idx] <= gen_ff[free_idx] + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= in_type;
         rpay_ff <= in_payload;
         rhnd_ff <= in_handle;
      end
      if (cmd.do_receive) begin
         spay_ff[free_idx] <= head_pay_ff;
         scnt_ff[free_idx] <= cnt_inc;
         srem_ff[free_idx] <= timeout;
      end
      if (cmd.tick_step && valid_ff[scan_ff] && !stat.scan_expire)
         srem_ff[scan_ff] <= srem_ff[scan_ff] - 16'd1;
      if (cmd.tick_clear) begin
         scan_ff <= '0;
         req_ff  <= '0;
      end else if (cmd.tick_step) begin
         if (!stat.scan_last) scan_ff <= scan_ff + SA'(1);
         if (cmd.tick_push) req_ff <= req_ff + 5'd1;
      end
      if (cmd.set_status) begin
         o_status   <= cmd.status;
         o_payload  <= 32'd0;
         o_count    <= 8'd0;
         o_handle   <= 12'd0;
         o_requeued <= 5'd0;
         if (cmd.do_receive) begin
            o_payload <= head_pay_ff;
            o_count   <= cnt_inc;
            o_handle  <= {gen_ff[free_idx] + 8'd1, 4'(free_idx)};
         end
         if (lqvt_pkg::req_kind_type'(type_ff) == lqvt_pkg::REQ_TICK)
            o_requeued <= req_ff + (cmd.tick_push ? 5'd1 : 5'd0);
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      ((FC+1)'(fill_ff) + (FC+1)'(held_ff)) <= (FC+1)'(FIFO_DEPTH))
      else $error("fifo plus leases exceed depth");
   a_held_count: assert property (@(posedge clock) disable iff (reset)
      32'(held_ff) == $countones(valid_ff))
      else $error("lease count mismatch");
   a_recv_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_receive |-> (fill_ff != '0) && free_any)
      else $error("receive without message or slot");
   a_ack_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.do_ack |=> !valid_ff[$past(ack_idx)])
      else $error("ack did not free slot");
endmodule

// File: rtl/core/lqvt_ctrl.sv
module lqvt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lqvt_pkg::stat_type stat,
   output lqvt_pkg::cmd_type  cmd
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DEC  = 6'b000010,
      S_HEAD = 6'b000100,
      S_RECV = 6'b001000,
      S_TICK = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status = lqvt_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.set_status = 1'b1;
            state_in = S_RESP;
            case (stat.kind)
               lqvt_pkg::REQ_PUBLISH: begin
                  if (stat.fifo_room) cmd.do_publish = 1'b1;
                  else cmd.status = lqvt_pkg::ST_FULL;
               end
               lqvt_pkg::REQ_RECEIVE: begin
                  if (!stat.fifo_nonempty) cmd.status = lqvt_pkg::ST_EMPTY;
                  else if (!stat.slot_free) cmd.status = lqvt_pkg::ST_FULL;
                  else begin
                     cmd.set_status = 1'b0;
                     cmd.rd_head = 1'b1;
                     state_in = S_HEAD;
                  end
               end
               lqvt_pkg::REQ_ACK: begin
                  if (stat.ack_match) cmd.do_ack = 1'b1;
                  else cmd.status = lqvt_pkg::ST_UNKNOWN;
               end
               default: begin
                  cmd.set_status = 1'b0;
                  cmd.tick_clear = 1'b1;
                  state_in = S_TICK;
               end
            endcase
         end
         S_HEAD: state_in = S_RECV;
         S_RECV: begin
            cmd.do_receive = 1'b1;
            cmd.set_status = 1'b1;
            state_in = S_RESP;
         end
         S_TICK: begin
            cmd.tick_step = 1'b1;
            cmd.tick_push = stat.scan_expire;
            if (stat.scan_last) begin
               cmd.set_status = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_single_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_publish && cmd.tick_push)) else $error("double fifo write");
endmodule

// File: rtl/core/lease_queue_with_visibility_timeout.sv
// Lease queue with visibility timeout. Requests arrive one word at a time on req and each
// yields exactly one rsp word; the block takes no new request until the previous response
// is taken. Receive reads the FIFO head through a registered memory read, and tick scans
// one lease slot per cycle; each expired lease writes the FIFO tail in its scan cycle.
// csr_wr_en with csr_wr_data sets visibility_timeout (reset value 1000); write it only
// while idle.
module lease_queue_with_visibility_timeout #(
   parameter int FIFO_DEPTH  = lqvt_pkg::FIFO_DEPTH_DEF,
   parameter int LEASE_SLOTS = lqvt_pkg::LEASE_SLOTS_DEF
) (
   input logic        clock,
   input logic        reset,
   lqvt_req_if.sink   req,
   lqvt_rsp_if.source rsp,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data
);
   logic [15:0] timeout_ff;
   lqvt_pkg::cmd_type  cmd;
   lqvt_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= lqvt_pkg::TIMEOUT_RESET;
      else if (csr_wr_en) timeout_ff <= csr_wr_data;
   end

   lqvt_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat, .cmd
   );

   lqvt_datapath #(.FIFO_DEPTH(FIFO_DEPTH), .LEASE_SLOTS(LEASE_SLOTS)) u_dp (
      .clock, .reset,
      .timeout(timeout_ff),
      .in_type(req.req_type), .in_payload(req.payload), .in_handle(req.handle),
      .cmd, .stat,
      .o_status(rsp.status), .o_payload(rsp.out_payload), .o_count(rsp.receive_count),
      .o_handle(rsp.out_handle), .o_requeued(rsp.requeued_count)
   );
endmodule
